/* rtl/ptns_pkg.sv */
// Package for the point table nearest search block.
// Holds payload structs, mode and status codes, register indexes and FSM states.
package ptns_pkg;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_SET    = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_FIND   = 3'd3,
    MODE_GET    = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_e;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFull    = 2'd1;
  localparam logic [1:0] StatusBad     = 2'd2;
  localparam logic [1:0] StatusNone    = 2'd3;

  localparam logic RegPointsLimit = 1'b0;
  localparam logic RegSpacesInUse = 1'b1;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         space;
    logic [5:0]         index;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        radius;
    logic               is_2d;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         out_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [30:0]        out_radius;
    logic               out_is_2d;
    logic [6:0]         point_count;
  } rsp_t;

  // One stored entry: x, y, z, radius, 2D flag.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] radius;
    logic        is_2d;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_GET,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

/* rtl/point_table_nearest_search_top.sv */
// Top level of the point table nearest search block.
// Depends on ptns_pkg; holds the table memory, the sequencer and the APB registers.
// Path from the accepting edge to the result strobe: set, clear, full, bad and unknown items go to done;
// get reads then loads; add writes each space in use; delete copies the last point in each space; find
// scans the stored points, one stored point read per cycle from the single memory read port.
// One item at a time: busy_o is high from the accepting edge until the strobe cycle.
// Reset clears the count and loads the registers; table contents are undefined.
module point_table_nearest_search_top #(
  parameter int POINT_SLOTS = 64,
  parameter int SPACE_COLS  = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ptns_pkg::cmd_t  cmd_i,
  output logic            busy_o,
  output logic            done_o,
  output ptns_pkg::rsp_t  rsp_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int IW    = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
  localparam int SW    = (SPACE_COLS > 1) ? $clog2(SPACE_COLS) : 1;
  localparam int AW    = IW + SW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = IW + 1;

  // Registers.
  logic [6:0] limit_q;
  logic [2:0] spaces_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= 7'd64;
      spaces_q <= 3'd2;
    end else if (wr_en) begin
      if (paddr[2] == ptns_pkg::RegPointsLimit) limit_q <= pwdata[6:0];
      else spaces_q <= pwdata[2:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ptns_pkg::RegPointsLimit) prdata[6:0] = limit_q;
    else prdata[2:0] = spaces_q;
  end

  logic [CW:0] eff_limit;
  logic [SW:0] eff_spaces;
  assign eff_limit  = (int'(limit_q) > POINT_SLOTS) ? (CW+1)'(POINT_SLOTS) :
                      (CW+1)'(limit_q);
  assign eff_spaces = (int'(spaces_q) > SPACE_COLS) ? (SW+1)'(SPACE_COLS) :
                      (SW+1)'(spaces_q);

  // Table memory, one write port and one read port, registered read.
  ptns_pkg::entry_t mem [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_wa, mem_ra;
  ptns_pkg::entry_t mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  // Sequencer state.
  ptns_pkg::state_e state_q, state_d;
  ptns_pkg::cmd_t   cmd_q, cmd_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q, ptr_d;        // point index being read
  logic [SW:0]      sp_q, sp_d;          // space walk for add/delete
  logic             rv_q, rv_d;          // scan read in flight
  logic [IW-1:0]    rix_q, rix_d;        // index of data in mem_rd_q
  logic             found_q, found_d;
  logic [33:0]      best_q, best_d;
  logic [IW-1:0]    bidx_q, bidx_d;
  logic [IW-1:0]    del_q, del_d;
  ptns_pkg::rsp_t   rsp_q, rsp_d;
  logic             done_q, done_d;

  // Distance test on the entry now at the read port.
  logic [32:0] dx, dy;
  logic [47:0] rx, ry;
  logic        hit;
  logic [33:0] dsum;
  always_comb begin
    dx = 33'($signed({cmd_q.x[31], cmd_q.x}) - $signed({mem_rd_q.x[31], mem_rd_q.x}));
    dy = 33'($signed({cmd_q.y[31], cmd_q.y}) - $signed({mem_rd_q.y[31], mem_rd_q.y}));
    if (dx[32]) dx = -dx;
    if (dy[32]) dy = -dy;
    rx = 48'(mem_rd_q.radius) * 48'(cmd_q.scale_x);
    ry = 48'(mem_rd_q.radius) * 48'(cmd_q.scale_y);
    hit  = ({7'd0, dx, 8'd0} <= rx) && ({7'd0, dy, 8'd0} <= ry);
    dsum = 34'(dx) + 34'(dy);
  end

  function automatic logic [AW-1:0] addr(input logic [SW:0] s, input logic [IW-1:0] i);
    return {s[SW-1:0], i};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptns_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      rv_q    <= rv_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ptr_q  <= ptr_d;
    sp_q   <= sp_d;
    rix_q  <= rix_d;
    best_q <= best_d;
    bidx_q <= bidx_d;
    del_q  <= del_d;
    rsp_q  <= rsp_d;
  end

  logic          sp_bad, ix_bad;
  logic [CW-1:0] last;
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    sp_d    = sp_q;
    rv_d    = 1'b0;
    rix_d   = rix_q;
    found_d = found_q;
    best_d  = best_q;
    bidx_d  = bidx_q;
    del_d   = del_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = addr(sp_q, ptr_q[IW-1:0]);
    mem_ra  = addr(sp_q, ptr_q[IW-1:0]);
    mem_wd  = '{x: cmd_q.x, y: cmd_q.y, z: cmd_q.z, radius: cmd_q.radius,
                is_2d: cmd_q.is_2d};
    sp_bad  = (SW+1)'(cmd_i.space) >= eff_spaces;
    ix_bad  = CW'(cmd_i.index) >= count_q || (cmd_i.index >> IW) != '0;
    last    = count_q - CW'(1);

    unique case (state_q)
      ptns_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          rsp_d = '0;
          sp_d  = '0;
          unique case (cmd_i.mode)
            ptns_pkg::MODE_ADD: begin
              if ((CW+1)'(count_q) >= eff_limit) begin
                rsp_d.status = ptns_pkg::StatusFull;
                state_d = ptns_pkg::ST_DONE;
              end else begin
                ptr_d = count_q;
                rsp_d.out_index = 6'(count_q);
                state_d = ptns_pkg::ST_ADD;
              end
            end
            ptns_pkg::MODE_SET: begin
              if (sp_bad || ix_bad) rsp_d.status = ptns_pkg::StatusBad;
              else begin
                mem_we = 1'b1;
                mem_wa = addr((SW+1)'(cmd_i.space), cmd_i.index[IW-1:0]);
                mem_wd = '{x: cmd_i.x, y: cmd_i.y, z: cmd_i.z,
                           radius: cmd_i.radius, is_2d: cmd_i.is_2d};
              end
              state_d = ptns_pkg::ST_DONE;
            end
            ptns_pkg::MODE_DELETE: begin
              if (ix_bad) begin
                rsp_d.status = ptns_pkg::StatusBad;
                state_d = ptns_pkg::ST_DONE;
              end else begin
                count_d = last;
                del_d   = cmd_i.index[IW-1:0];
                ptr_d   = last;
                state_d = ptns_pkg::ST_MOVE_RD;
              end
            end
            ptns_pkg::MODE_FIND: begin
              if (sp_bad) begin
                rsp_d.status = ptns_pkg::StatusBad;
                state_d = ptns_pkg::ST_DONE;
              end else begin
                sp_d    = (SW+1)'(cmd_i.space);
                ptr_d   = '0;
                found_d = 1'b0;
                state_d = ptns_pkg::ST_SCAN;
              end
            end
            ptns_pkg::MODE_GET: begin
              if (sp_bad || ix_bad) begin
                rsp_d.status = ptns_pkg::StatusBad;
                state_d = ptns_pkg::ST_DONE;
              end else begin
                mem_ra  = addr((SW+1)'(cmd_i.space), cmd_i.index[IW-1:0]);
                state_d = ptns_pkg::ST_GET;
              end
            end
            ptns_pkg::MODE_CLEAR: begin
              count_d = '0;
              state_d = ptns_pkg::ST_DONE;
            end
            default: state_d = ptns_pkg::ST_DONE;
          endcase
        end
      end
      ptns_pkg::ST_ADD: begin
        if (sp_q >= eff_spaces) begin
          count_d = count_q + CW'(1);
          state_d = ptns_pkg::ST_DONE;
        end else begin
          mem_we = 1'b1;
          sp_d   = sp_q + (SW+1)'(1);
        end
      end
      ptns_pkg::ST_MOVE_RD: begin
        if (sp_q >= eff_spaces) state_d = ptns_pkg::ST_DONE;
        else state_d = ptns_pkg::ST_MOVE_WR;
      end
      ptns_pkg::ST_MOVE_WR: begin
        mem_we  = 1'b1;
        mem_wa  = addr(sp_q, del_q);
        mem_wd  = mem_rd_q;
        sp_d    = sp_q + (SW+1)'(1);
        state_d = ptns_pkg::ST_MOVE_RD;
      end
      ptns_pkg::ST_GET: begin
        rsp_d.out_x      = mem_rd_q.x;
        rsp_d.out_y      = mem_rd_q.y;
        rsp_d.out_z      = mem_rd_q.z;
        rsp_d.out_radius = mem_rd_q.radius;
        rsp_d.out_is_2d  = mem_rd_q.is_2d;
        state_d = ptns_pkg::ST_DONE;
      end
      ptns_pkg::ST_SCAN: begin
        // Issue one read per cycle; evaluate the previous one.
        if (rv_q && hit && (!found_q || dsum < best_q)) begin
          found_d = 1'b1;
          best_d  = dsum;
          bidx_d  = rix_q;
        end
        if (ptr_q < count_q) begin
          rv_d  = 1'b1;
          rix_d = ptr_q[IW-1:0];
          ptr_d = ptr_q + CW'(1);
        end else if (!rv_q) begin
          rsp_d.status    = found_q ? ptns_pkg::StatusOk : ptns_pkg::StatusNone;
          rsp_d.out_index = found_q ? 6'(bidx_q) : 6'd0;
          state_d = ptns_pkg::ST_DONE;
        end
      end
      ptns_pkg::ST_DONE: begin
        rsp_d.point_count = 7'(count_q);
        done_d  = 1'b1;
        state_d = ptns_pkg::ST_IDLE;
      end
      default: state_d = ptns_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ptns_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held two cycles");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_o) else $error("result while busy");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW+1)'(count_q) <= (CW+1)'(POINT_SLOTS)) else $error("count above table size");
  a_scan_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ptns_pkg::ST_SCAN |-> sp_q < eff_spaces)
    else $error("scan in unused space");

endmodule

/* verif/point_table_nearest_search_top_tb.sv */
// Self-checking testbench for point_table_nearest_search_top.
// Depends on ptns_pkg; a scoreboard class mirrors the point table and checks each result beat.

class point_table_board;
  logic signed [31:0] tx[4][64];
  logic signed [31:0] ty[4][64];
  logic signed [31:0] tz[4][64];
  logic [30:0]        trad[4][64];
  logic               tflat[4][64];
  int unsigned        point_total;
  int unsigned        limit_reg;
  int unsigned        spaces_reg;
  ptns_pkg::rsp_t     pending[$];
  int                 errors;
  int                 checked;

  function new();
    point_total = 0;
    limit_reg   = 64;
    spaces_reg  = 2;
    errors      = 0;
    checked     = 0;
  endfunction

  function int unsigned limit_eff();
    return (limit_reg > 64) ? 64 : limit_reg;
  endfunction

  function int unsigned spaces_eff();
    return (spaces_reg > 4) ? 4 : spaces_reg;
  endfunction

  function void store(int s, int i, ptns_pkg::cmd_t c);
    tx[s][i]    = c.x;
    ty[s][i]    = c.y;
    tz[s][i]    = c.z;
    trad[s][i]  = c.radius;
    tflat[s][i] = c.is_2d;
  endfunction

  function longint unsigned abs_gap(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? longint'(-d) : d;
  endfunction

  function ptns_pkg::rsp_t predict(ptns_pkg::cmd_t c);
    ptns_pkg::rsp_t r;
    int unsigned spc;
    bit found;
    longint unsigned best, dx, dy, lim_x, lim_y;
    r = '0;
    spc = spaces_eff();
    found = 0;
    best = 0;
    case (ptns_pkg::mode_e'(c.mode))
      ptns_pkg::MODE_ADD: begin
        if (point_total >= limit_eff()) begin
          r.status = ptns_pkg::StatusFull;
        end else begin
          for (int s = 0; s < spc; s++) store(s, point_total, c);
          r.out_index = point_total[5:0];
          point_total++;
        end
      end
      ptns_pkg::MODE_SET: begin
        if (c.space >= spc || c.index >= point_total) r.status = ptns_pkg::StatusBad;
        else store(c.space, c.index, c);
      end
      ptns_pkg::MODE_DELETE: begin
        if (c.index >= point_total) begin
          r.status = ptns_pkg::StatusBad;
        end else begin
          point_total--;
          for (int s = 0; s < spc; s++) begin
            tx[s][c.index]    = tx[s][point_total];
            ty[s][c.index]    = ty[s][point_total];
            tz[s][c.index]    = tz[s][point_total];
            trad[s][c.index]  = trad[s][point_total];
            tflat[s][c.index] = tflat[s][point_total];
          end
        end
      end
      ptns_pkg::MODE_FIND: begin
        if (c.space >= spc) begin
          r.status = ptns_pkg::StatusBad;
        end else begin
          for (int i = 0; i < point_total; i++) begin
            dx = abs_gap(c.x, tx[c.space][i]);
            dy = abs_gap(c.y, ty[c.space][i]);
            lim_x = longint'(trad[c.space][i]) * longint'(c.scale_x);
            lim_y = longint'(trad[c.space][i]) * longint'(c.scale_y);
            // Compare with 8 fraction bits (scale as Q8.8): the distance shifted by 8 against radius times scale.
            if ((dx << 8) <= lim_x && (dy << 8) <= lim_y) begin
              if (!found || dx + dy < best) begin
                found = 1;
                best = dx + dy;
                r.out_index = i[5:0];
              end
            end
          end
          if (!found) r.status = ptns_pkg::StatusNone;
        end
      end
      ptns_pkg::MODE_GET: begin
        if (c.space >= spc || c.index >= point_total) begin
          r.status = ptns_pkg::StatusBad;
        end else begin
          r.out_x      = tx[c.space][c.index];
          r.out_y      = ty[c.space][c.index];
          r.out_z      = tz[c.space][c.index];
          r.out_radius = trad[c.space][c.index];
          r.out_is_2d  = tflat[c.space][c.index];
        end
      end
      ptns_pkg::MODE_CLEAR: point_total = 0;
      default: ;
    endcase
    r.point_count = point_total[6:0];
    return r;
  endfunction

  function void note_command(ptns_pkg::cmd_t c);
    pending.push_back(predict(c));
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task check_response(ptns_pkg::rsp_t got);
    ptns_pkg::rsp_t want;
    if (pending.size() == 0) begin
      report("result beat with nothing expected");
    end else begin
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.out_index !== want.out_index)
        report($sformatf("out_index %0d, expected %0d", got.out_index, want.out_index));
      if (got.out_x !== want.out_x)
        report($sformatf("out_x %h, expected %h", got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report($sformatf("out_y %h, expected %h", got.out_y, want.out_y));
      if (got.out_z !== want.out_z)
        report($sformatf("out_z %h, expected %h", got.out_z, want.out_z));
      if (got.out_radius !== want.out_radius)
        report($sformatf("out_radius %h, expected %h", got.out_radius, want.out_radius));
      if (got.out_is_2d !== want.out_is_2d)
        report($sformatf("out_is_2d %b, expected %b", got.out_is_2d, want.out_is_2d));
      if (got.point_count !== want.point_count)
        report($sformatf("point_count %0d, expected %0d", got.point_count,
                         want.point_count));
    end
  endtask
endclass

module point_table_nearest_search_top_tb;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  ptns_pkg::cmd_t cmd_i;
  logic           busy_o;
  logic           done_o;
  ptns_pkg::rsp_t rsp_o;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  point_table_board board;
  int items_sent;
  int phases_run;

  point_table_nearest_search_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .cmd_i(cmd_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_response(rsp_o);
  end

  // Drives one command and holds it until the block takes it.
  task automatic issue(ptns_pkg::cmd_t c);
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o);
    board.note_command(c);
    items_sent++;
  endtask

  task automatic pause(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits for every outstanding result so the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == ptns_pkg::RegPointsLimit) board.limit_reg = value & 32'h7f;
    else board.spaces_reg = value & 32'h7;
  endtask

  function automatic ptns_pkg::cmd_t plain(ptns_pkg::mode_e m, int s, int i);
    ptns_pkg::cmd_t c;
    c = '0;
    c.mode  = m;
    c.space = 2'(s);
    c.index = 6'(i);
    return c;
  endfunction

  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  function automatic ptns_pkg::cmd_t random_cmd();
    ptns_pkg::cmd_t c;
    int unsigned pick, spc, cnt, j;
    c = '0;
    spc = board.spaces_eff();
    cnt = board.point_total;
    pick = $urandom_range(0, 99);
    if (pick < 30)      c.mode = ptns_pkg::MODE_ADD;
    else if (pick < 40) c.mode = ptns_pkg::MODE_SET;
    else if (pick < 50) c.mode = ptns_pkg::MODE_DELETE;
    else if (pick < 75) c.mode = ptns_pkg::MODE_FIND;
    else if (pick < 92) c.mode = ptns_pkg::MODE_GET;
    else if (pick < 94) c.mode = ptns_pkg::MODE_CLEAR;
    else                c.mode = 3'($urandom_range(6, 7));
    c.space = ($urandom_range(0, 99) < 85 && spc > 0) ? 2'($urandom_range(0, spc - 1))
                                                       : 2'($urandom);
    c.index = ($urandom_range(0, 99) < 80 && cnt > 0) ? 6'($urandom_range(0, cnt - 1))
                                                       : 6'($urandom);
    c.x = $urandom;
    c.y = $urandom;
    c.z = $urandom;
    c.radius = 31'($urandom);
    c.is_2d = 1'($urandom);
    c.scale_x = 16'($urandom);
    c.scale_y = 16'($urandom);
    if ($urandom_range(0, 99) < 70) begin
      c.x = near_coord();
      c.y = near_coord();
    end
    if ($urandom_range(0, 99) < 70) c.radius = 31'($urandom_range(0, 32'h0010_0000));
    if ($urandom_range(0, 99) < 70) begin
      c.scale_x = 16'($urandom_range(0, 16'h0400));
      c.scale_y = 16'($urandom_range(0, 16'h0400));
    end
    if (cnt > 0 && spc > 0 && $urandom_range(0, 99) < 50) begin
      j = $urandom_range(0, cnt - 1);
      if (c.mode == ptns_pkg::MODE_FIND && c.space < spc) begin
        // Query close to a stored point so that the search has something to find.
        c.x = board.tx[c.space][j] + $signed($urandom_range(0, 32'h1_0000)) - 32'sh8000;
        c.y = board.ty[c.space][j] + $signed($urandom_range(0, 32'h1_0000)) - 32'sh8000;
      end else if (c.mode == ptns_pkg::MODE_ADD) begin
        // A duplicate position gives the search a tie to settle.
        c.x = board.tx[0][j];
        c.y = board.ty[0][j];
      end
    end
    return c;
  endfunction

  task automatic random_phase(int unsigned limit, int unsigned spaces, int n, bit gaps);
    int burst;
    drain();
    issue(plain(ptns_pkg::MODE_CLEAR, 0, 0));
    drain();
    write_reg(ptns_pkg::RegPointsLimit, limit);
    write_reg(ptns_pkg::RegSpacesInUse, spaces);
    phases_run++;
    burst = $urandom_range(1, 20);
    for (int k = 0; k < n; k++) begin
      issue(random_cmd());
      burst--;
      if (burst == 0) begin
        if (gaps) pause($urandom_range(1, 6));
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  initial begin
    #50_000_000;
    $display("Timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    ptns_pkg::cmd_t c;
    int wait_cycles;
    board = new();
    items_sent = 0;
    phases_run = 0;
    clk_i   = 1'b0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    cmd_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part: empty table, field extremes, every mode, bad space and index.
    issue(plain(ptns_pkg::MODE_GET, 0, 0));
    issue(plain(ptns_pkg::MODE_FIND, 0, 0));
    c = plain(ptns_pkg::MODE_ADD, 0, 0);
    c.x = 32'sh7fff_ffff; c.y = 32'sh8000_0000; c.z = 32'sh7fff_ffff;
    c.radius = 31'h7fff_ffff; c.is_2d = 1'b1;
    issue(c);
    c = plain(ptns_pkg::MODE_ADD, 0, 0);
    c.x = 32'sh8000_0000; c.y = 32'sh7fff_ffff; c.z = 32'sh8000_0000;
    issue(c);
    c = plain(ptns_pkg::MODE_FIND, 1, 0);
    c.x = 32'sh8000_0000; c.y = 32'sh7fff_ffff; c.scale_x = 16'hffff; c.scale_y = 16'hffff;
    issue(c);
    c.space = 2'd3;
    issue(c);
    issue(plain(ptns_pkg::MODE_GET, 1, 0));
    issue(plain(ptns_pkg::MODE_GET, 0, 63));
    c = plain(ptns_pkg::MODE_SET, 1, 1);
    c.x = 32'sh0001_0000; c.radius = 31'h0001_0000; c.scale_x = 16'h0100;
    c.scale_y = 16'h0100;
    issue(c);
    issue(plain(ptns_pkg::MODE_GET, 1, 1));
    issue(plain(ptns_pkg::MODE_SET, 3, 0));
    issue(plain(ptns_pkg::MODE_DELETE, 0, 5));
    issue(plain(ptns_pkg::MODE_DELETE, 0, 0));
    issue(plain(ptns_pkg::MODE_GET, 0, 0));
    issue(plain(ptns_pkg::mode_e'(3'd6), 0, 0));
    issue(plain(ptns_pkg::mode_e'(3'd7), 0, 0));
    issue(plain(ptns_pkg::MODE_CLEAR, 0, 0));
    drain();
    write_reg(ptns_pkg::RegPointsLimit, 0);
    issue(plain(ptns_pkg::MODE_ADD, 0, 0));
    drain();
    write_reg(ptns_pkg::RegPointsLimit, 127);
    repeat (65) issue(plain(ptns_pkg::MODE_ADD, 0, 0));
    drain();
    write_reg(ptns_pkg::RegPointsLimit, 3);
    issue(plain(ptns_pkg::MODE_ADD, 0, 0));
    issue(plain(ptns_pkg::MODE_CLEAR, 0, 0));
    drain();
    write_reg(ptns_pkg::RegSpacesInUse, 0);
    issue(plain(ptns_pkg::MODE_ADD, 0, 0));
    issue(plain(ptns_pkg::MODE_SET, 0, 0));
    issue(plain(ptns_pkg::MODE_GET, 0, 0));
    issue(plain(ptns_pkg::MODE_FIND, 0, 0));
    issue(plain(ptns_pkg::MODE_DELETE, 0, 0));

    random_phase(64, 4, 120, 1);
    random_phase(5, 1, 60, 0);
    random_phase(127, 7, 120, 1);
    random_phase(20, 3, 100, 1);
    random_phase(1, 2, 40, 0);
    random_phase(64, 2, 120, 1);

    start_i <= 1'b0;
    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (80) @(posedge clk_i);
    if (board.pending.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending.size()));
    $display("Ran %0d commands over %0d register settings; %0d result beats checked.",
             items_sent, phases_run + 4, board.checked);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ptns_pkg.sv
rtl/point_table_nearest_search_top.sv
verif/point_table_nearest_search_top_tb.sv
